// ----- rtl/cpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// types, codes and limits shared by the column post picture decoder
// ----------------------------------------------------------------------------
package cpd_pkg;

   // clip limits of the decoder
   localparam int MAX_TEX_DIM       = 1024;
   localparam int MAX_PATCH_COLUMNS = 1024;

   // queue depths
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // byte that ends a column
   localparam logic [7:0] END_OF_COLUMN = 8'hFF;
   // alpha forced into every pixel
   localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;

   // request codes
   localparam logic [1:0] REQ_PAL_WRITE = 2'd0;
   localparam logic [1:0] REQ_START     = 2'd1;
   localparam logic [1:0] REQ_DATA      = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ORIGIN_X   = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y   = 2'd1;
   localparam logic [1:0] CSR_TEX_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_TEX_HEIGHT = 2'd3;

   localparam logic [10:0] TEX_DIM_RESET = 11'd64;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [10:0] tex_width;
      logic [10:0] tex_height;
   } cfg_type;

   // work handed from front to back
   typedef struct packed {
      logic        is_pixel;   // 0 palette write, 1 pixel
      logic [7:0]  index;      // palette entry or pixel index
      logic [23:0] rgb;
      logic [9:0]  column;
      logic [8:0]  row;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);
   localparam int OUT_W = 52;

endpackage

// ----- rtl/column_post_picture_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_post_picture_decoder
// decodes one column of posts of a paletted picture into texture pixel writes
// ----------------------------------------------------------------------------
//  channel   ports                       moves
//  request   req_push / req_full         one stream word: palette write,
//                                        column start or post data byte
//  result    rsp_pop / rsp_empty         one pixel word: address and argb
//  csr       csr_valid / csr_ready       one register write, index and data
//
//  a word can be taken every cycle while req_full is low; a drawn pixel passes
//  from its data byte to the result side through front parse, command queue,
//  palette read, address multiply and result queue
//  reset is synchronous; it idles the parser and empties both queues, the
//  palette holds nothing defined until written
//  req_full rises only when the four-entry command queue is full, which
//  happens when the result side stops popping and the back end stalls
// ----------------------------------------------------------------------------
module column_post_picture_decoder (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_type,
   input  logic [9:0]  req_column,
   input  logic [7:0]  req_pal_index,
   input  logic [23:0] req_pal_rgb,
   input  logic [7:0]  req_data_byte,
   // result words
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [19:0] rsp_pixel_addr,
   output logic [31:0] rsp_pixel_argb,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import cpd_pkg::*;

   localparam int CMD_CNT_W = $clog2(CMD_DEPTH+1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // front to back command queue
   logic                 accept;
   logic                 cmd_push;
   cmd_type              cmd_wr;
   logic [CMD_W-1:0]     cmd_head;
   logic                 cmd_pop;
   logic [CMD_CNT_W-1:0] cmd_count;

   // back to result queue
   logic                 out_push;
   logic [OUT_W-1:0]     out_wr;
   logic [OUT_W-1:0]     out_head;
   logic [OUT_CNT_W-1:0] out_count;
   logic                 out_pop;

   // registers are always writable; writes must only come while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata;
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata;
            CSR_TEX_WIDTH:  cfg_in.tex_width  = csr_wdata[10:0];
            CSR_TEX_HEIGHT: cfg_in.tex_height = csr_wdata[10:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.tex_width  <= TEX_DIM_RESET;
         cfg_ff.tex_height <= TEX_DIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a word is taken whenever the command queue has room; words that
   // issue no command still advance the parser
   assign req_full = (cmd_count == CMD_CNT_W'(CMD_DEPTH));
   assign accept   = req_push && !req_full;

   cpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .req_column    (req_column),
      .req_pal_index (req_pal_index),
      .req_pal_rgb   (req_pal_rgb),
      .req_data_byte (req_data_byte),
      .cmd_push      (cmd_push),
      .cmd           (cmd_wr)
   );

   cpd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .pop       (cmd_pop),
      .head_data (cmd_head),
      .count     (cmd_count)
   );

   // back end keeps palette writes and pixel reads in stream order
   cpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_count == '0),
      .cmd       (cmd_type'(cmd_head)),
      .cmd_pop   (cmd_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_wr)
   );

   // result queue, parts the back end from the consumer
   assign out_pop = rsp_pop && !rsp_empty;

   cpd_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr),
      .pop       (out_pop),
      .head_data (out_head),
      .count     (out_count)
   );

   assign rsp_empty      = (out_count == '0);
   assign rsp_pixel_addr = out_head[51:32];
   assign rsp_pixel_argb = out_head[31:0];

endmodule

// ----- rtl/cpd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_fifo
// small register queue with fill count, head shown combinationally
// ----------------------------------------------------------------------------
module cpd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             head_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- rtl/cpd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_front
// post stream parser: tracks the post phase and issues palette writes and pixels
// ----------------------------------------------------------------------------
module cpd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [1:0]       req_type,
   input  logic [9:0]       req_column,
   input  logic [7:0]       req_pal_index,
   input  logic [23:0]      req_pal_rgb,
   input  logic [7:0]       req_data_byte,
   output logic             cmd_push,
   output cpd_pkg::cmd_type cmd
);
   import cpd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TOP,
      PH_LEN,
      PH_PAD,
      PH_PIX,
      PH_TRAIL
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [9:0] column_ff, column_in;
   logic [7:0] top_row_ff, top_row_in;
   logic [8:0] row_ff, row_in;
   logic [7:0] left_ff, left_in;

   always_comb begin
      phase_in   = phase_ff;
      column_in  = column_ff;
      top_row_in = top_row_ff;
      row_in     = row_ff;
      left_in    = left_ff;
      cmd_push   = 1'b0;
      cmd.is_pixel = 1'b0;
      cmd.index    = req_pal_index;
      cmd.rgb      = req_pal_rgb;
      cmd.column   = column_ff;
      cmd.row      = row_ff;
      if (accept) begin
         case (req_type)
            REQ_PAL_WRITE: begin
               cmd_push = 1'b1;
            end
            REQ_START: begin
               if (32'(req_column) < MAX_PATCH_COLUMNS) begin
                  column_in = req_column;
                  phase_in  = PH_TOP;
               end else begin
                  phase_in  = PH_IDLE;
               end
            end
            REQ_DATA: begin
               case (phase_ff)
                  PH_TOP: begin
                     if (req_data_byte == END_OF_COLUMN) begin
                        phase_in = PH_IDLE;
                     end else begin
                        top_row_in = req_data_byte;
                        phase_in   = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     left_in  = req_data_byte;
                     row_in   = {1'b0, top_row_ff};
                     phase_in = PH_PAD;
                  end
                  PH_PAD: begin
                     phase_in = (left_ff == 8'd0) ? PH_TRAIL : PH_PIX;
                  end
                  PH_TRAIL: begin
                     phase_in = PH_TOP;
                  end
                  PH_PIX: begin
                     cmd_push     = 1'b1;
                     cmd.is_pixel = 1'b1;
                     cmd.index    = req_data_byte;
                     row_in       = row_ff + 9'd1;
                     left_in      = left_ff - 8'd1;
                     if (left_ff == 8'd1) begin
                        phase_in = PH_TRAIL;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         column_ff  <= '0;
         top_row_ff <= '0;
         row_ff     <= '0;
         left_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         column_ff  <= column_in;
         top_row_ff <= top_row_in;
         row_ff     <= row_in;
         left_ff    <= left_in;
      end
   end

endmodule

// ----- rtl/cpd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_back
// palette store, placement and clipping, address multiply, result push
// ----------------------------------------------------------------------------
module cpd_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cpd_pkg::cfg_type                        cfg,
   input  logic                                    cmd_empty,
   input  cpd_pkg::cmd_type                        cmd,
   output logic                                    cmd_pop,
   input  logic [$clog2(cpd_pkg::OUT_DEPTH+1)-1:0] out_count,
   output logic                                    out_push,
   output logic [cpd_pkg::OUT_W-1:0]               out_data
);
   import cpd_pkg::*;

   localparam int CNT_W = $clog2(OUT_DEPTH+1);

   logic [23:0] palette [256];

   logic [10:0] w, h;
   logic [17:0] rx, ry;
   logic        in_tex;
   logic [CNT_W:0] pending;

   logic        s1_valid_ff, s1_valid_in;
   logic [10:0] s1_rx_ff, s1_ry_ff;
   logic [23:0] s1_rgb_ff;

   logic        s2_valid_ff;
   logic [21:0] s2_prod_ff;
   logic [10:0] s2_rx_ff;
   logic [31:0] s2_argb_ff;

   logic [19:0] addr;

   // clip the texture size to the supported maximum
   always_comb begin
      w = (32'(cfg.tex_width) > MAX_TEX_DIM) ? 11'(MAX_TEX_DIM) : cfg.tex_width;
      h = (32'(cfg.tex_height) > MAX_TEX_DIM) ? 11'(MAX_TEX_DIM) : cfg.tex_height;
   end

   // only issue when every pixel in flight has a slot in the result queue
   always_comb begin
      pending = {1'b0, out_count} + (CNT_W+1)'(s1_valid_ff) + (CNT_W+1)'(s2_valid_ff);
      cmd_pop = !cmd_empty && (32'(pending) < OUT_DEPTH);
   end

   always_comb begin
      rx = {8'b0, cmd.column} + {{2{cfg.origin_x[15]}}, cfg.origin_x};
      ry = {9'b0, cmd.row}    + {{2{cfg.origin_y[15]}}, cfg.origin_y};
      in_tex = !rx[17] && !ry[17] && (rx < {7'b0, w}) && (ry < {7'b0, h});
      s1_valid_in = cmd_pop && cmd.is_pixel && in_tex;
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && !cmd.is_pixel) begin
         palette[cmd.index] <= cmd.rgb;
      end
      s1_rgb_ff <= palette[cmd.index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_rx_ff   <= rx[10:0];
      s1_ry_ff   <= ry[10:0];
      s2_prod_ff <= {11'b0, s1_ry_ff} * {11'b0, w};
      s2_rx_ff   <= s1_rx_ff;
      s2_argb_ff <= ALPHA_OPAQUE | {8'b0, s1_rgb_ff};
   end

   assign addr     = 20'(s2_prod_ff + {11'b0, s2_rx_ff});
   assign out_push = s2_valid_ff;
   assign out_data = {addr, s2_argb_ff};

endmodule
